[sv/crtti_pkg.sv]
package crtti_pkg;

  localparam int unsigned MAX_DIGITS = 16;
  localparam int unsigned SYM_SLOTS  = 16;

  localparam logic [1:0] CFG_SYM_LOW  = 2'd0;
  localparam logic [1:0] CFG_SYM_HIGH = 2'd1;
  localparam logic [1:0] CFG_COUNT    = 2'd2;

  localparam logic [63:0] SYM_LOW_RST  = 64'd3978425819141910832;
  localparam logic [63:0] SYM_HIGH_RST = 64'd14648;
  localparam logic [4:0]  COUNT_RST    = 5'd10;

  localparam logic [4:0] MAX_RADIX = 5'(MAX_DIGITS);

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [SYM_SLOTS-1:0][7:0] symbols;
    logic [4:0]                radix;
    logic                      bad;
  } alpha_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        ovf;
    logic        bad;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_FF) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_TAB) || (c == CH_VT);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

[sv/custom_radix_text_to_integer_core.sv]
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall   | text_byte, end_of_text
// output  | out       | out_valid / out_stall | parsed_value, overflowed, alphabet_invalid
// config  | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle unless stalled: input register, one parse step (64x5 multiply-add),
// result register. A held result stalls an end-of-text byte in the input register.
// Reset restores the decimal alphabet "0123456789" and clears the parser.
// out_stall holds only an end-of-text byte; other bytes keep flowing behind a full result.
module custom_radix_text_to_integer_core
  import crtti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] parsed_value,
  output logic        overflowed,
  output logic        alphabet_invalid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  alpha_t     alpha;
  result_t    step_res;
  result_t    res;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eot;
  logic       out_free;
  logic       adv;
  logic       accept;

  crtti_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alpha     (alpha)
  );

  crtti_parser u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (adv),
    .text_byte   (s1_byte),
    .end_of_text (s1_eot),
    .alpha       (alpha),
    .result      (step_res)
  );

  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && (!s1_eot || out_free);
  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= text_byte;
      s1_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_eot) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_eot) begin
      res <= step_res;
    end
  end

  assign parsed_value     = res.neg ? (64'd0 - res.mag) : res.mag;
  assign overflowed       = res.ovf;
  assign alphabet_invalid = res.bad;

endmodule

[sv/crtti_cfg_regs.sv]
module crtti_cfg_regs
  import crtti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output alpha_t      alpha
);

  logic [63:0] sym_low;
  logic [63:0] sym_high;
  logic [4:0]  count;
  logic        bad;
  logic        bad_next;
  logic [4:0]  radix;
  logic [SYM_SLOTS-1:0][7:0] syms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_low  <= SYM_LOW_RST;
      sym_high <= SYM_HIGH_RST;
      count    <= COUNT_RST;
      bad      <= 1'b0;
    end else begin
      bad <= bad_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SYM_LOW:  sym_low  <= cfg_data;
          CFG_SYM_HIGH: sym_high <= cfg_data;
          CFG_COUNT:    count    <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  assign radix = (count > MAX_RADIX) ? MAX_RADIX : count;
  assign syms  = {sym_high, sym_low};

  // validity registered; config changes only while idle: user's duty, not enforced
  always_comb begin
    bad_next = (radix < 5'd2);
    for (int i = 0; i < SYM_SLOTS; i++) begin
      if (5'(i) < radix) begin
        if (syms[i] == CH_NUL || is_sign(syms[i]) || is_space(syms[i])) begin
          bad_next = 1'b1;
        end
        for (int j = i + 1; j < SYM_SLOTS; j++) begin
          if (5'(j) < radix && syms[j] == syms[i]) begin
            bad_next = 1'b1;
          end
        end
      end
    end
  end

  assign alpha.symbols = syms;
  assign alpha.radix   = radix;
  assign alpha.bad     = bad;

endmodule

[sv/crtti_parser.sv]
module crtti_parser
  import crtti_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  alpha_t     alpha,
  output result_t    result
);

  phase_t      phase;
  phase_t      phase_next;
  logic        neg;
  logic        neg_next;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic        ovf;
  logic        ovf_next;

  logic        hit;
  logic [3:0]  dval;
  logic [68:0] sum;

  // lowest matching slot wins
  always_comb begin
    hit  = 1'b0;
    dval = '0;
    for (int k = SYM_SLOTS - 1; k >= 0; k--) begin
      if (5'(k) < alpha.radix && alpha.symbols[k] == text_byte && text_byte != CH_NUL) begin
        hit  = 1'b1;
        dval = 4'(k);
      end
    end
  end

  assign sum = ({5'b0, acc} * {64'b0, alpha.radix}) + {65'b0, dval};

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_next   = acc;
    ovf_next   = ovf;
    unique case (phase)
      PH_SPACE, PH_SIGN, PH_DIGIT: begin
        if (phase == PH_SPACE && is_space(text_byte)) begin
          phase_next = PH_SPACE;
        end else if (phase != PH_DIGIT && is_sign(text_byte)) begin
          neg_next   = neg ^ (text_byte == CH_MINUS);
          phase_next = PH_SIGN;
        end else if (hit) begin
          acc_next   = sum[63:0];
          ovf_next   = ovf | (sum[68:64] != 5'd0);
          phase_next = PH_DIGIT;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    if (alpha.bad) begin
      result.mag = '0;
      result.neg = 1'b0;
      result.ovf = 1'b0;
      result.bad = 1'b1;
    end else begin
      result.mag = acc_next;
      result.neg = neg_next;
      result.ovf = ovf_next;
      result.bad = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      neg   <= 1'b0;
      acc   <= '0;
      ovf   <= 1'b0;
    end else if (step) begin
      if (end_of_text) begin
        phase <= PH_SPACE;
        neg   <= 1'b0;
        acc   <= '0;
        ovf   <= 1'b0;
      end else begin
        phase <= phase_next;
        neg   <= neg_next;
        acc   <= acc_next;
        ovf   <= ovf_next;
      end
    end
  end

endmodule

[tb/sv/tb.sv]
module tb;
  import crtti_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int BYTES_PER_PHASE = 40;
  localparam int LAST_PHASE      = 18;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  typedef struct {
    logic [63:0] value;
    logic        ovf;
    logic        bad;
  } parse_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} stall_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] parsed_value;
  logic        overflowed;
  logic        alphabet_invalid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  custom_radix_text_to_integer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .parsed_value(parsed_value),
    .overflowed(overflowed),
    .alphabet_invalid(alphabet_invalid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  text_item_t    text_bytes_q[$];
  parse_result_t parse_results_q[$];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  bit            stall_off = 1'b0;

  // alphabet copy and parser state
  logic [63:0] alpha_lo = SYM_LOW_RST;
  logic [63:0] alpha_hi = SYM_HIGH_RST;
  logic [4:0]  alpha_count = COUNT_RST;
  phase_t      ps_phase = PH_SPACE;
  logic        ps_neg = 1'b0;
  logic        ps_ovf = 1'b0;
  logic [63:0] ps_acc = 64'd0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    $display("mismatch %s: got %h wanted %h", what, got, wanted);
    mismatch_count++;
  endtask

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SPACE || c == CH_FF || c == CH_LF || c == CH_CR ||
           c == CH_TAB || c == CH_VT;
  endfunction

  function automatic logic [7:0] ws_pick();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_FF;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_TAB;
      default: return CH_VT;
    endcase
  endfunction

  function automatic logic [4:0] radix_now();
    return (alpha_count > MAX_RADIX) ? MAX_RADIX : alpha_count;
  endfunction

  function automatic logic [7:0] symbol_at(input int k);
    logic [127:0] w;
    w = {alpha_hi, alpha_lo};
    return w[8*k +: 8];
  endfunction

  function automatic int digit_of(input logic [7:0] c);
    int r;
    r = radix_now();
    if (c == CH_NUL) return -1;
    for (int k = 0; k < r; k++)
      if (symbol_at(k) == c) return k;
    return -1;
  endfunction

  function automatic logic alphabet_bad();
    int r;
    logic [7:0] s;
    r = radix_now();
    if (r < 2) return 1'b1;
    for (int i = 0; i < r; i++) begin
      s = symbol_at(i);
      if (s == CH_NUL || s == CH_PLUS || s == CH_MINUS || is_ws(s)) return 1'b1;
      for (int j = i + 1; j < r; j++)
        if (symbol_at(j) == s) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int d;
    logic [69:0] wide;
    d = digit_of(c);
    if (d < 0) begin
      ps_phase = PH_DONE;
    end else begin
      wide = {6'd0, ps_acc} * 70'(radix_now()) + 70'(d);
      if (wide[69:64] != 6'd0) ps_ovf = 1'b1;
      ps_acc = wide[63:0];
      ps_phase = PH_DIGIT;
    end
  endfunction

  function automatic void sign_or_digit(input logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) begin
      if (c == CH_MINUS) ps_neg = !ps_neg;
      ps_phase = PH_SIGN;
    end else begin
      take_digit(c);
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c, input logic last);
    parse_result_t r;
    case (ps_phase)
      PH_SPACE: if (!is_ws(c)) sign_or_digit(c);
      PH_SIGN:  sign_or_digit(c);
      PH_DIGIT: take_digit(c);
      default: ;
    endcase
    if (last) begin
      if (alphabet_bad()) begin
        r.value = 64'd0;
        r.ovf = 1'b0;
        r.bad = 1'b1;
      end else begin
        r.value = ps_neg ? 64'd0 - ps_acc : ps_acc;
        r.ovf = ps_ovf;
        r.bad = 1'b0;
      end
      parse_results_q.push_back(r);
      ps_phase = PH_SPACE;
      ps_neg = 1'b0;
      ps_ovf = 1'b0;
      ps_acc = 64'd0;
    end
  endfunction

  function automatic logic [127:0] random_alphabet();
    bit used[256];
    logic [127:0] w;
    logic [7:0] c;
    for (int k = 0; k < 16; k++) begin
      do c = 8'($urandom_range(1, 255));
      while (used[c] || c == CH_PLUS || c == CH_MINUS || is_ws(c));
      used[c] = 1'b1;
      w[8*k +: 8] = c;
    end
    return w;
  endfunction

  function automatic void add_byte(input logic [7:0] c, input logic last);
    text_item_t it;
    it.ch = c;
    it.last = last;
    text_bytes_q.push_back(it);
  endfunction

  // mostly well-formed numbers, some with one corrupted byte, some pure noise
  function automatic void queue_texts(input int nbytes);
    logic [7:0] t[$];
    int total, kind, n, r, pos;
    total = 0;
    r = radix_now();
    while (total < nbytes) begin
      t.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        n = $urandom_range(1, 8);
        repeat (n) t.push_back(8'($urandom));
      end else begin
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) t.push_back(ws_pick());
        if ($urandom_range(0, 1))
          repeat ($urandom_range(1, 3)) t.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        if ($urandom_range(0, 9) == 0)
          n = (r <= 4) ? $urandom_range(30, 70) : $urandom_range(12, 24);
        else
          n = $urandom_range(1, 10);
        repeat (n) t.push_back((r > 0) ? symbol_at($urandom_range(0, r - 1)) : 8'($urandom));
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) t.push_back(8'($urandom));
        if (kind >= 7) begin
          pos = $urandom_range(0, t.size() - 1);
          case ($urandom_range(0, 3))
            0: t[pos] = CH_NUL;
            1: t[pos] = ws_pick();
            2: t[pos] = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
            default: t[pos] = 8'($urandom);
          endcase
        end
      end
      for (int k = 0; k < t.size(); k++) add_byte(t[k], k == t.size() - 1);
      total += t.size();
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SYM_LOW:  alpha_lo = data;
      CFG_SYM_HIGH: alpha_hi = data;
      CFG_COUNT:    alpha_count = data[4:0];
      default: ;
    endcase
  endtask

  task automatic program_alphabet(input logic [127:0] w, input logic [63:0] count_word,
                                  input bit spare);
    @(posedge clk);
    if (spare) write_reg(CFG_SPARE, {$urandom, $urandom});
    write_reg(CFG_SYM_LOW, w[63:0]);
    write_reg(CFG_SYM_HIGH, w[127:64]);
    write_reg(CFG_COUNT, count_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (text_bytes_q.size() != 0 || in_valid || parse_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [127:0] w;
    logic [63:0]  count_word;
    int cnt, i, j;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // decimal alphabet from reset: every blank, sign runs, zero byte, 0xff
    add_byte(CH_TAB, 0); add_byte(CH_LF, 0); add_byte(CH_VT, 0);
    add_byte(CH_FF, 0); add_byte(CH_CR, 0); add_byte(CH_SPACE, 0);
    add_byte(CH_MINUS, 0); add_byte(CH_PLUS, 0); add_byte(CH_MINUS, 0);
    add_byte(CH_MINUS, 0); add_byte("9", 0); add_byte("8", 1);
    add_byte("5", 0); add_byte(CH_NUL, 0); add_byte("7", 1);
    add_byte(8'hff, 1);
    add_byte(CH_MINUS, 1);
    add_byte("0", 0); add_byte("3", 0); add_byte(CH_SPACE, 0); add_byte("4", 1);
    add_byte("1", 0); add_byte(CH_PLUS, 1);
    queue_texts(BYTES_PER_PHASE);

    for (int p = 1; p <= LAST_PHASE; p++) begin
      w = random_alphabet();
      cnt = $urandom_range(2, 16);
      i = $urandom_range(0, cnt - 1);
      count_word = 64'd0;
      case (p)
        1: begin
          w = {64'h6665646362613938, 64'h3736353433323130};
          cnt = 16;
        end
        2: cnt = 2;
        3: cnt = 16;
        4: cnt = 0;
        5: cnt = 1;
        6: begin
          cnt = 31;
          count_word = '1;
        end
        7: cnt = 17;
        8: begin
          i = $urandom_range(0, cnt - 2);
          j = $urandom_range(i + 1, cnt - 1);
          w[8*j +: 8] = w[8*i +: 8];
        end
        9:  w[8*i +: 8] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        10: w[8*i +: 8] = ws_pick();
        11: w[8*i +: 8] = CH_NUL;
        12: begin
          w = '1;
          cnt = 16;
        end
        13: begin
          w = '0;
          cnt = 2;
        end
        14: begin
          w[127:64] = w[63:0];
          cnt = 8;
        end
        LAST_PHASE: begin
          w = {SYM_HIGH_RST, SYM_LOW_RST};
          cnt = COUNT_RST;
        end
        default: ;
      endcase
      count_word[4:0] = 5'(cnt);
      settle();
      program_alphabet(w, count_word, p == 1);
      queue_texts(BYTES_PER_PHASE);
    end

    // text left open: no result may appear
    add_byte(CH_SPACE, 0); add_byte("4", 0); add_byte("2", 0);

    stall_off = 1'b1;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (parse_results_q.size() != 0)
      report_mismatch("results never arrived", 64'(parse_results_q.size()), 64'd0);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    int burst_left;
    int gap_left;
    int bursts;
    bit drain_hold;
    text_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
      bursts = 0;
      drain_hold = 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_byte(text_byte, end_of_text);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (drain_hold && parse_results_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (text_bytes_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          drain_hold = 1'b0;
          nxt = text_bytes_q.pop_front();
          in_valid <= 1'b1;
          text_byte <= nxt.ch;
          end_of_text <= nxt.last;
          burst_left--;
          if (burst_left <= 0) begin
            bursts++;
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            drain_hold = (bursts % 12 == 3) || ($urandom_range(0, 15) == 0);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    parse_result_t want;
    stall_mode_t mode;
    int mode_left;
    int wave;
    if (rst) begin
      out_stall <= 1'b0;
      mode = STALL_NONE;
      mode_left = 0;
      wave = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parse_results_q.size() == 0) begin
          report_mismatch("unrequested result", parsed_value, 64'd0);
        end else begin
          want = parse_results_q.pop_front();
          if (parsed_value !== want.value)
            report_mismatch("parsed_value", parsed_value, want.value);
          if (overflowed !== want.ovf)
            report_mismatch("overflowed", 64'(overflowed), 64'(want.ovf));
          if (alphabet_invalid !== want.bad)
            report_mismatch("alphabet_invalid", 64'(alphabet_invalid), 64'(want.bad));
        end
      end
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      wave++;
      if (stall_off) begin
        out_stall <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= wave[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule
